// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the triangle angle RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`endif
`endif

// ----- hdl/tas_pkg.sv -----
// Package: widths, CORDIC angle table and pipeline flags for the triangle angle block.
`timescale 1ns / 1ps
package tas_pkg;
   localparam int LEN_W = 32;
   localparam int ANG_W = 31;
   localparam int ANGLE_FRAC_BITS = 29;
   localparam int COS_FRAC = 30;
   localparam int ACC_FRAC = 62;
   localparam int CORDIC_STEPS = 32;
   localparam int GUARD = 2;
   localparam int PROD_W = 2 * LEN_W;
   localparam int SUM_W = PROD_W + 1;
   localparam int DIFF_W = SUM_W + 1;
   localparam int QUO_W = COS_FRAC;
   localparam int ROOT_W = COS_FRAC + 1;
   localparam int SQ_W = 2 * ROOT_W;
   localparam int RAD_W = 2 * COS_FRAC + 1;
   localparam int SQRT_STEPS = COS_FRAC + 1;
   localparam int XY_W = ROOT_W + GUARD + 3;
   localparam int Z_W = 64;
   localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int COS_STAGES = 3 + QUO_W;
   localparam int LATENCY = 2 + COS_STAGES + 3 + SQRT_STEPS + 1 + CORDIC_STEPS + 3;

   typedef logic [Z_W-1:0] atan_tab_type [CORDIC_STEPS];

   typedef struct packed {
      logic valid;
      logic zero;
      logic clamp;
      logic neg;
      logic full;
      logic skip;
   } flags_type;

   function automatic logic [Z_W-1:0] atan_pow2(input int i);
      logic [Z_W-1:0] sum;
      int e;
      sum = '0;
      for (int k = 0; k < ACC_FRAC; k++) begin
         e = ACC_FRAC - i * (2 * k + 1);
         if (e >= 0) begin
            if ((k & 1) == 0) sum = sum + ((Z_W'(1) << e) / Z_W'(2 * k + 1));
            else sum = sum - ((Z_W'(1) << e) / Z_W'(2 * k + 1));
         end
      end
      return sum;
   endfunction

   function automatic logic [Z_W-1:0] atan_fifth();
      logic [Z_W-1:0] p;
      logic [Z_W-1:0] sum;
      p = (Z_W'(1) << ACC_FRAC) / Z_W'(5);
      sum = '0;
      for (int k = 0; k < 32; k++) begin
         if ((k & 1) == 0) sum = sum + p / Z_W'(2 * k + 1);
         else sum = sum - p / Z_W'(2 * k + 1);
         p = p / Z_W'(25);
      end
      return sum;
   endfunction

   function automatic logic [Z_W-1:0] atan_239th();
      logic [Z_W-1:0] p;
      logic [Z_W-1:0] sum;
      p = (Z_W'(1) << ACC_FRAC) / Z_W'(239);
      sum = '0;
      for (int k = 0; k < 32; k++) begin
         if ((k & 1) == 0) sum = sum + p / Z_W'(2 * k + 1);
         else sum = sum - p / Z_W'(2 * k + 1);
         p = p / Z_W'(57121);
      end
      return sum;
   endfunction

   function automatic atan_tab_type atan_table();
      atan_tab_type t;
      t[0] = (Z_W'(4) * atan_fifth()) - atan_239th();
      for (int i = 1; i < CORDIC_STEPS; i++) t[i] = atan_pow2(i);
      return t;
   endfunction

   localparam atan_tab_type ATAN_TAB = atan_table();
   localparam logic [Z_W-1:0] HALF_PI = ATAN_TAB[0] << 1;
   localparam logic [Z_W-1:0] PI = ATAN_TAB[0] << 2;
   localparam logic [Z_W-1:0] ROUND_ADD = Z_W'(1) << (ROUND_SHIFT - 1);
   localparam logic [ANG_W-1:0] ANG_MAX = ANG_W'((PI + ROUND_ADD) >> ROUND_SHIFT);
   localparam logic [ANG_W-1:0] ANG_HALF_MIN = ANG_W'(HALF_PI >> ROUND_SHIFT);
   localparam logic [ROOT_W-1:0] COS_ONE = ROOT_W'(1) << COS_FRAC;
   localparam logic [RAD_W-1:0] COS_ONE_SQ = RAD_W'(1) << (2 * COS_FRAC);
endpackage

// ----- hdl/triangle_angles_from_sides_top.sv -----
// Triangle angles from three sides: squares stage, three cosine lanes and three arccos lanes.
// Throughput: one request per cycle; busy never rises, the pipeline has no stall.
// Depth is set by the 30-stage divider, 31-stage square root and 32-stage CORDIC.
// Reset clears only the stage flag registers; the pipeline is ready on the next cycle.
// The receiver cannot stall: rsp_valid marks each result for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module triangle_angles_from_sides_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tas_pkg::LEN_W-1:0]         req_side_a,
   input  logic [tas_pkg::LEN_W-1:0]         req_side_b,
   input  logic [tas_pkg::LEN_W-1:0]         req_side_c,
   output logic                              rsp_valid,
   output logic [tas_pkg::ANG_W-1:0]         rsp_angle_a,
   output logic [tas_pkg::ANG_W-1:0]         rsp_angle_b,
   output logic [tas_pkg::ANG_W-1:0]         rsp_angle_c,
   output logic                              rsp_degenerate
);
   logic                          take;
   tas_pkg::flags_type            s0_flags_ff;
   tas_pkg::flags_type            s0_flags_in;
   tas_pkg::flags_type            s1_flags_ff;
   logic [tas_pkg::LEN_W-1:0]     a_ff;
   logic [tas_pkg::LEN_W-1:0]     b_ff;
   logic [tas_pkg::LEN_W-1:0]     c_ff;
   logic [tas_pkg::PROD_W-1:0]    sq_a_ff;
   logic [tas_pkg::PROD_W-1:0]    sq_b_ff;
   logic [tas_pkg::PROD_W-1:0]    sq_c_ff;
   logic [tas_pkg::PROD_W-1:0]    p_ab_ff;
   logic [tas_pkg::PROD_W-1:0]    p_ac_ff;
   logic [tas_pkg::PROD_W-1:0]    p_bc_ff;

   tas_pkg::flags_type            cos_flags_a;
   tas_pkg::flags_type            cos_flags_b;
   tas_pkg::flags_type            cos_flags_c;
   logic [tas_pkg::QUO_W-1:0]     quo_a;
   logic [tas_pkg::QUO_W-1:0]     quo_b;
   logic [tas_pkg::QUO_W-1:0]     quo_c;
   tas_pkg::flags_type            out_flags_a;
   tas_pkg::flags_type            out_flags_b;
   tas_pkg::flags_type            out_flags_c;

   assign busy = 1'b0;
   assign take = start && !busy;

   always_comb begin
      s0_flags_in = '0;
      s0_flags_in.valid = take;
      s0_flags_in.zero = (req_side_a == '0) || (req_side_b == '0) || (req_side_c == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_flags_ff <= '0;
         s1_flags_ff <= '0;
      end else begin
         s0_flags_ff <= s0_flags_in;
         s1_flags_ff <= s0_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= req_side_a;
      b_ff <= req_side_b;
      c_ff <= req_side_c;
      sq_a_ff <= a_ff * a_ff;
      sq_b_ff <= b_ff * b_ff;
      sq_c_ff <= c_ff * c_ff;
      p_ab_ff <= a_ff * b_ff;
      p_ac_ff <= a_ff * c_ff;
      p_bc_ff <= b_ff * c_ff;
   end

   tas_cos u_cos_a (
      .clock    (clock),
      .reset    (reset),
      .in_flags (s1_flags_ff),
      .opp_sq   (sq_a_ff),
      .s_sq     (sq_b_ff),
      .u_sq     (sq_c_ff),
      .su_prod  (p_bc_ff),
      .out_flags(cos_flags_a),
      .out_quo  (quo_a)
   );

   tas_cos u_cos_b (
      .clock    (clock),
      .reset    (reset),
      .in_flags (s1_flags_ff),
      .opp_sq   (sq_b_ff),
      .s_sq     (sq_a_ff),
      .u_sq     (sq_c_ff),
      .su_prod  (p_ac_ff),
      .out_flags(cos_flags_b),
      .out_quo  (quo_b)
   );

   tas_cos u_cos_c (
      .clock    (clock),
      .reset    (reset),
      .in_flags (s1_flags_ff),
      .opp_sq   (sq_c_ff),
      .s_sq     (sq_a_ff),
      .u_sq     (sq_b_ff),
      .su_prod  (p_ab_ff),
      .out_flags(cos_flags_c),
      .out_quo  (quo_c)
   );

   tas_acos u_acos_a (
      .clock    (clock),
      .reset    (reset),
      .in_flags (cos_flags_a),
      .in_quo   (quo_a),
      .out_flags(out_flags_a),
      .out_angle(rsp_angle_a)
   );

   tas_acos u_acos_b (
      .clock    (clock),
      .reset    (reset),
      .in_flags (cos_flags_b),
      .in_quo   (quo_b),
      .out_flags(out_flags_b),
      .out_angle(rsp_angle_b)
   );

   tas_acos u_acos_c (
      .clock    (clock),
      .reset    (reset),
      .in_flags (cos_flags_c),
      .in_quo   (quo_c),
      .out_flags(out_flags_c),
      .out_angle(rsp_angle_c)
   );

   assign rsp_valid = out_flags_a.valid;
   assign rsp_degenerate = out_flags_a.zero || out_flags_a.clamp || out_flags_b.clamp
                           || out_flags_c.clamp;

   `ASSERT_IMPL(a_rsp_from_request, clock, reset, rsp_valid, $past(take, tas_pkg::LATENCY))
   `ASSERT_ALWAYS(a_lanes_aligned, clock, reset, (out_flags_a.valid == out_flags_b.valid) && (out_flags_b.valid == out_flags_c.valid))
   `ASSERT_IMPL(a_zero_side_out, clock, reset, rsp_valid && out_flags_a.zero, rsp_degenerate && (rsp_angle_a == '0) && (rsp_angle_b == '0) && (rsp_angle_c == '0))
endmodule

// ----- hdl/tas_cos.sv -----
// Cosine lane: law of cosines magnitude, clamp test and restoring divide, one bit a stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tas_cos (
   input  logic                              clock,
   input  logic                              reset,
   input  tas_pkg::flags_type                in_flags,
   input  logic [tas_pkg::PROD_W-1:0]        opp_sq,
   input  logic [tas_pkg::PROD_W-1:0]        s_sq,
   input  logic [tas_pkg::PROD_W-1:0]        u_sq,
   input  logic [tas_pkg::PROD_W-1:0]        su_prod,
   output tas_pkg::flags_type                out_flags,
   output logic [tas_pkg::QUO_W-1:0]         out_quo
);
   tas_pkg::flags_type                 c1_flags_ff;
   logic [tas_pkg::SUM_W-1:0]          sum_ff;
   logic [tas_pkg::PROD_W-1:0]         opp_ff;
   logic [tas_pkg::SUM_W-1:0]          den1_ff;

   tas_pkg::flags_type                 c2_flags_ff;
   tas_pkg::flags_type                 c2_flags_in;
   logic [tas_pkg::SUM_W-1:0]          mag_ff;
   logic [tas_pkg::SUM_W-1:0]          den2_ff;
   logic [tas_pkg::DIFF_W-1:0]         diff_pos;
   logic [tas_pkg::DIFF_W-1:0]         diff_neg;

   tas_pkg::flags_type                 c3_flags_in;

   tas_pkg::flags_type                 df_ff  [0:tas_pkg::QUO_W];
   logic [tas_pkg::SUM_W-1:0]          rem_ff [0:tas_pkg::QUO_W];
   logic [tas_pkg::SUM_W-1:0]          den_ff [0:tas_pkg::QUO_W];
   logic [tas_pkg::QUO_W-1:0]          quo_ff [0:tas_pkg::QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_flags_ff <= '0;
      end else begin
         c1_flags_ff <= in_flags;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= {1'b0, s_sq} + {1'b0, u_sq};
      opp_ff  <= opp_sq;
      den1_ff <= {su_prod, 1'b0};
   end

   always_comb begin
      diff_pos = {1'b0, sum_ff} - {2'b00, opp_ff};
      diff_neg = {2'b00, opp_ff} - {1'b0, sum_ff};
      c2_flags_in = c1_flags_ff;
      c2_flags_in.neg = diff_pos[tas_pkg::DIFF_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_flags_ff <= '0;
      end else begin
         c2_flags_ff <= c2_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= diff_pos[tas_pkg::DIFF_W-1] ? diff_neg[tas_pkg::SUM_W-1:0]
                                             : diff_pos[tas_pkg::SUM_W-1:0];
      den2_ff <= den1_ff;
   end

   always_comb begin
      c3_flags_in = c2_flags_ff;
      c3_flags_in.clamp = mag_ff > den2_ff;
      c3_flags_in.full = mag_ff >= den2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         df_ff[0] <= '0;
      end else begin
         df_ff[0] <= c3_flags_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= mag_ff;
      den_ff[0] <= den2_ff;
      quo_ff[0] <= '0;
   end

   for (genvar k = 0; k < tas_pkg::QUO_W; k++) begin : g_div
      logic [tas_pkg::DIFF_W-1:0] shifted;
      logic [tas_pkg::DIFF_W-1:0] trial;
      logic                       ge;
      logic [tas_pkg::SUM_W-1:0]  rem_in;

      always_comb begin
         shifted = {rem_ff[k], 1'b0};
         trial = shifted - {1'b0, den_ff[k]};
         ge = shifted >= {1'b0, den_ff[k]};
         rem_in = ge ? trial[tas_pkg::SUM_W-1:0] : shifted[tas_pkg::SUM_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            df_ff[k+1] <= '0;
         end else begin
            df_ff[k+1] <= df_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         den_ff[k+1] <= den_ff[k];
         quo_ff[k+1] <= {quo_ff[k][tas_pkg::QUO_W-2:0], ge};
      end
   end

   assign out_flags = df_ff[tas_pkg::QUO_W];
   assign out_quo = quo_ff[tas_pkg::QUO_W];

   `ASSERT_IMPL(a_cos_latency, clock, reset, out_flags.valid, $past(in_flags.valid, tas_pkg::COS_STAGES))
   `ASSERT_IMPL(a_cos_clamp_full, clock, reset, out_flags.valid && out_flags.clamp, out_flags.full)
endmodule

// ----- hdl/tas_acos.sv -----
// Arccosine lane: square root of one minus cos squared, CORDIC vectoring and rounding.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tas_acos (
   input  logic                              clock,
   input  logic                              reset,
   input  tas_pkg::flags_type                in_flags,
   input  logic [tas_pkg::QUO_W-1:0]         in_quo,
   output tas_pkg::flags_type                out_flags,
   output logic [tas_pkg::ANG_W-1:0]         out_angle
);
   tas_pkg::flags_type                 af_ff [0:1];
   logic [tas_pkg::ROOT_W-1:0]         q0_ff;
   logic [tas_pkg::ROOT_W-1:0]         q1_ff;
   logic [tas_pkg::SQ_W-1:0]           qsq_ff;

   tas_pkg::flags_type                 sf_ff  [0:tas_pkg::SQRT_STEPS];
   logic [tas_pkg::RAD_W-1:0]          rad_ff [0:tas_pkg::SQRT_STEPS];
   logic [tas_pkg::RAD_W-1:0]          res_ff [0:tas_pkg::SQRT_STEPS];
   logic [tas_pkg::ROOT_W-1:0]         sq_q_ff [0:tas_pkg::SQRT_STEPS];

   tas_pkg::flags_type                 cf_ff [0:tas_pkg::CORDIC_STEPS];
   tas_pkg::flags_type                 cf_in;
   logic signed [tas_pkg::XY_W-1:0]    x_ff [0:tas_pkg::CORDIC_STEPS];
   logic signed [tas_pkg::XY_W-1:0]    y_ff [0:tas_pkg::CORDIC_STEPS];
   logic signed [tas_pkg::Z_W-1:0]     z_ff [0:tas_pkg::CORDIC_STEPS];
   logic [tas_pkg::ROOT_W-1:0]         root;

   tas_pkg::flags_type                 ff_ff [0:2];
   logic [tas_pkg::Z_W-1:0]            zc_ff;
   logic [tas_pkg::Z_W-1:0]            zc_in;
   logic [tas_pkg::Z_W-1:0]            theta_ff;
   logic [tas_pkg::Z_W-1:0]            rounded;
   logic [tas_pkg::ANG_W-1:0]          angle_ff;
   logic [tas_pkg::ANG_W-1:0]          angle_in;

   // cosine magnitude, then its square
   always_ff @(posedge clock) begin
      if (reset) begin
         af_ff[0] <= '0;
         af_ff[1] <= '0;
         sf_ff[0] <= '0;
      end else begin
         af_ff[0] <= in_flags;
         af_ff[1] <= af_ff[0];
         sf_ff[0] <= af_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= in_flags.full ? tas_pkg::COS_ONE : {1'b0, in_quo};
      q1_ff <= q0_ff;
      qsq_ff <= q0_ff * q0_ff;
      rad_ff[0] <= tas_pkg::COS_ONE_SQ - qsq_ff[tas_pkg::RAD_W-1:0];
      res_ff[0] <= '0;
      sq_q_ff[0] <= q1_ff;
   end

   for (genvar j = 0; j < tas_pkg::SQRT_STEPS; j++) begin : g_sqrt
      logic [tas_pkg::RAD_W-1:0] step_bit;
      logic [tas_pkg::RAD_W:0]   trial;
      logic                      ge;
      logic [tas_pkg::RAD_W-1:0] rad_in;
      logic [tas_pkg::RAD_W-1:0] res_in;

      always_comb begin
         step_bit = tas_pkg::RAD_W'(1) << (tas_pkg::RAD_W - 1 - 2 * j);
         trial = {1'b0, res_ff[j]} + {1'b0, step_bit};
         ge = {1'b0, rad_ff[j]} >= trial;
         rad_in = ge ? rad_ff[j] - trial[tas_pkg::RAD_W-1:0] : rad_ff[j];
         res_in = ge ? (res_ff[j] >> 1) + step_bit : res_ff[j] >> 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sf_ff[j+1] <= '0;
         end else begin
            sf_ff[j+1] <= sf_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[j+1] <= rad_in;
         res_ff[j+1] <= res_in;
         sq_q_ff[j+1] <= sq_q_ff[j];
      end
   end

   always_comb begin
      root = res_ff[tas_pkg::SQRT_STEPS][tas_pkg::ROOT_W-1:0];
      cf_in = sf_ff[tas_pkg::SQRT_STEPS];
      cf_in.skip = root == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cf_ff[0] <= '0;
      end else begin
         cf_ff[0] <= cf_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= tas_pkg::XY_W'({sq_q_ff[tas_pkg::SQRT_STEPS], {tas_pkg::GUARD{1'b0}}});
      y_ff[0] <= tas_pkg::XY_W'({root, {tas_pkg::GUARD{1'b0}}});
      z_ff[0] <= '0;
   end

   for (genvar i = 0; i < tas_pkg::CORDIC_STEPS; i++) begin : g_cordic
      logic signed [tas_pkg::XY_W-1:0] dx;
      logic signed [tas_pkg::XY_W-1:0] dy;
      logic signed [tas_pkg::Z_W-1:0]  ang;
      logic                            pos;
      logic signed [tas_pkg::XY_W-1:0] x_in;
      logic signed [tas_pkg::XY_W-1:0] y_in;
      logic signed [tas_pkg::Z_W-1:0]  z_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         ang = signed'(tas_pkg::ATAN_TAB[i]);
         pos = !y_ff[i][tas_pkg::XY_W-1] && (y_ff[i] != '0);
         if (cf_ff[i].skip) begin
            x_in = x_ff[i];
            y_in = y_ff[i];
            z_in = z_ff[i];
         end else if (pos) begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + ang;
         end else begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cf_ff[i+1] <= '0;
         end else begin
            cf_ff[i+1] <= cf_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1] <= x_in;
         y_ff[i+1] <= y_in;
         z_ff[i+1] <= z_in;
      end
   end

   // clamp to [0, pi/2], fold for a negative cosine, round
   always_comb begin
      if (z_ff[tas_pkg::CORDIC_STEPS][tas_pkg::Z_W-1]) begin
         zc_in = '0;
      end else if ($unsigned(z_ff[tas_pkg::CORDIC_STEPS]) > tas_pkg::HALF_PI) begin
         zc_in = tas_pkg::HALF_PI;
      end else begin
         zc_in = $unsigned(z_ff[tas_pkg::CORDIC_STEPS]);
      end
      rounded = (theta_ff + tas_pkg::ROUND_ADD) >> tas_pkg::ROUND_SHIFT;
      angle_in = ff_ff[1].zero ? '0 : rounded[tas_pkg::ANG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_ff[0] <= '0;
         ff_ff[1] <= '0;
         ff_ff[2] <= '0;
      end else begin
         ff_ff[0] <= cf_ff[tas_pkg::CORDIC_STEPS];
         ff_ff[1] <= ff_ff[0];
         ff_ff[2] <= ff_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      zc_ff <= zc_in;
      theta_ff <= ff_ff[0].neg ? tas_pkg::PI - zc_ff : zc_ff;
      angle_ff <= angle_in;
   end

   assign out_flags = ff_ff[2];
   assign out_angle = angle_ff;

   `ASSERT_IMPL(a_obtuse_range, clock, reset, out_flags.valid && out_flags.neg && !out_flags.zero, out_angle >= tas_pkg::ANG_HALF_MIN)
   `ASSERT_IMPL(a_angle_max, clock, reset, out_flags.valid, out_angle <= tas_pkg::ANG_MAX)
endmodule
